>>> rtl/dec_private_mode_sniffer_core_defines.svh
// Assertion macros for the private-mode sniffer core.
// Included by the top level; has no other dependencies.
`ifndef DEC_PRIVATE_MODE_SNIFFER_CORE_DEFINES_SVH
`define DEC_PRIVATE_MODE_SNIFFER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Check that a condition implies another in the same cycle
`define DPMS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dpms same-cycle check failed");

// Check that a condition implies another in the next cycle
`define DPMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dpms next-cycle check failed");

`else

`define DPMS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define DPMS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/dpms_pkg.sv
// Shared types and byte constants for the private-mode sniffer.
// No dependencies; imported by every module of the block.
package dpms_pkg;

   // Parser phases
   typedef enum logic [1:0] {
      PHASE_GROUND = 2'd0,
      PHASE_ESC    = 2'd1,
      PHASE_CSI    = 2'd2,
      PHASE_PARAMS = 2'd3
   } phase_type;

   // Bytes the parser reacts to
   localparam logic [7:0] BYTE_ESC      = 8'h1b;
   localparam logic [7:0] BYTE_LBRACKET = 8'h5b;
   localparam logic [7:0] BYTE_QUERY    = 8'h3f;
   localparam logic [7:0] BYTE_SEMI     = 8'h3b;
   localparam logic [7:0] BYTE_SET      = 8'h68;
   localparam logic [7:0] BYTE_CLEAR    = 8'h6c;
   localparam logic [7:0] BYTE_ZERO     = 8'h30;
   localparam logic [7:0] BYTE_NINE     = 8'h39;

   // Known private modes and accumulator limit
   localparam logic [15:0] MODE_CURSOR = 16'd1;
   localparam logic [15:0] MODE_PASTE  = 16'd2004;
   localparam logic [15:0] ACC_MAX     = 16'hffff;

   typedef struct packed {
      logic app_cursor_keys;
      logic bracketed_paste;
   } flags_type;

   // Parser status seen by the top level
   typedef struct packed {
      phase_type phase;
      flags_type cur_flags;
      flags_type next_flags;
   } status_type;

endpackage

>>> rtl/dec_private_mode_sniffer_core.sv
// Terminal private-mode sniffer: watches ESC [ ? Pm ; ... h/l sequences.
// Input byte words arrive on req_, one result word per byte leaves on rsp_.
// Each result carries the application cursor keys flag (mode 1) and the
// bracketed paste flag (mode 2004) as they stand after that byte.
// A byte accepted into the input register moves on to the result register,
// and its result is presented on rsp_, as soon as that register is free.
// Throughput: one byte per cycle while rsp_ready stays high. Parser state
// updates once per byte, in one pass between input and result registers.
// Reset (synchronous, active high) returns the parser to ground, clears
// both flags and empties both registers.
// When the receiver stalls, the result word holds and the input register
// still takes one more byte; after that req_ready drops until rsp_ready
// returns. No word is dropped or repeated.
`include "dec_private_mode_sniffer_core_defines.svh"

module dec_private_mode_sniffer_core
   import dpms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_app_cursor_keys,
   output logic       rsp_bracketed_paste
);

   logic       word_valid;
   logic [7:0] word_byte;
   logic       can_load;
   logic       advance;
   status_type status;
   flags_type  rsp_flags;
   logic       out_stall;
   logic       word_is_final;
   logic       flags_same;
   logic       result_in_step;
   logic       query_in_csi;

   // Move the held byte on when the result register is free
   assign advance = word_valid && can_load;

   dpms_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .advance       (advance),
      .word_valid    (word_valid),
      .word_byte     (word_byte)
   );

   dpms_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .word_byte (word_byte),
      .status    (status)
   );

   dpms_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_flags (status.next_flags),
      .can_load   (can_load),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_flags  (rsp_flags)
   );

   assign rsp_app_cursor_keys = rsp_flags.app_cursor_keys;
   assign rsp_bracketed_paste = rsp_flags.bracketed_paste;

   // Conditions watched by the checks below
   assign out_stall      = word_valid && rsp_valid && !rsp_ready;
   assign word_is_final  = (word_byte == BYTE_SET) || (word_byte == BYTE_CLEAR);
   assign flags_same     = (status.next_flags == status.cur_flags);
   assign result_in_step = rsp_valid && (rsp_flags == status.cur_flags);
   assign query_in_csi   = advance && (status.phase == PHASE_CSI)
                           && (word_byte == BYTE_QUERY);

   // Back-pressure only when both registers are full and the output stalls
   `DPMS_ASSERT_IMPLY(a_ready_only_on_stall, clock, reset, !req_ready, out_stall)

   // Bytes other than a final leave both flags alone
   `DPMS_ASSERT_IMPLY(a_flags_keep, clock, reset, advance && !word_is_final, flags_same)

   // A loaded result word carries the flags the parser then holds
   `DPMS_ASSERT_NEXT(a_result_matches, clock, reset, advance, result_in_step)

   // ESC [ ? opens the parameter list
   `DPMS_ASSERT_NEXT(a_enter_params, clock, reset, query_in_csi, status.phase == PHASE_PARAMS)

endmodule

>>> rtl/dpms_in_stage.sv
// Input register of the private-mode sniffer: holds one byte word.
// Depends on dpms_pkg.
module dpms_in_stage
   import dpms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       advance,
   output logic       word_valid,
   output logic [7:0] word_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       accept;

   // Take a new word when empty or when the held word moves on
   assign req_ready = !valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold payload; no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_data_byte;
      end
   end

   assign word_valid = valid_ff;
   assign word_byte  = byte_ff;

endmodule

>>> rtl/dpms_parser.sv
// Escape-sequence parser and mode flags of the private-mode sniffer.
// Depends on dpms_pkg.
module dpms_parser
   import dpms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [7:0] word_byte,
   output status_type status
);

   phase_type   phase_ff, phase_in;
   logic [15:0] acc_ff, acc_in;
   logic        digit_seen_ff, digit_seen_in;
   logic        pend_one_ff, pend_one_in;
   logic        pend_paste_ff, pend_paste_in;
   flags_type   flags_ff, flags_in;

   logic        is_digit;
   logic [19:0] acc_wide;
   logic [19:0] acc_prod;
   logic        match_one;
   logic        match_paste;
   logic        final_one;
   logic        final_paste;
   logic        set_mode;

   // Multiply by ten as two shifts and add the digit
   assign is_digit = (word_byte >= BYTE_ZERO) && (word_byte <= BYTE_NINE);
   assign acc_wide = {4'd0, acc_ff};
   assign acc_prod = (acc_wide << 3) + (acc_wide << 1)
                   + {16'd0, word_byte[3:0]};

   // Match the current parameter against the known modes
   assign match_one   = (acc_ff == MODE_CURSOR);
   assign match_paste = (acc_ff == MODE_PASTE);
   assign final_one   = pend_one_ff || (digit_seen_ff && match_one);
   assign final_paste = pend_paste_ff || (digit_seen_ff && match_paste);
   assign set_mode    = (word_byte == BYTE_SET);

   // Next state for one byte
   always_comb begin
      phase_in      = phase_ff;
      acc_in        = acc_ff;
      digit_seen_in = digit_seen_ff;
      pend_one_in   = pend_one_ff;
      pend_paste_in = pend_paste_ff;
      flags_in      = flags_ff;
      unique case (phase_ff)
         PHASE_GROUND: begin
            if (word_byte == BYTE_ESC) begin
               phase_in = PHASE_ESC;
            end
         end
         PHASE_ESC: begin
            phase_in = (word_byte == BYTE_LBRACKET) ? PHASE_CSI : PHASE_GROUND;
         end
         PHASE_CSI: begin
            if (word_byte == BYTE_QUERY) begin
               phase_in      = PHASE_PARAMS;
               acc_in        = '0;
               digit_seen_in = 1'b0;
               pend_one_in   = 1'b0;
               pend_paste_in = 1'b0;
            end else begin
               phase_in = (word_byte == BYTE_ESC) ? PHASE_ESC : PHASE_GROUND;
            end
         end
         PHASE_PARAMS: begin
            priority if (is_digit) begin
               acc_in        = (acc_prod > {4'd0, ACC_MAX}) ? ACC_MAX : acc_prod[15:0];
               digit_seen_in = 1'b1;
            end else if (word_byte == BYTE_SEMI) begin
               pend_one_in   = pend_one_ff || match_one;
               pend_paste_in = pend_paste_ff || match_paste;
               acc_in        = '0;
               digit_seen_in = 1'b0;
            end else if (set_mode || (word_byte == BYTE_CLEAR)) begin
               pend_one_in   = final_one;
               pend_paste_in = final_paste;
               if (final_one) begin
                  flags_in.app_cursor_keys = set_mode;
               end
               if (final_paste) begin
                  flags_in.bracketed_paste = set_mode;
               end
               phase_in = PHASE_GROUND;
            end else begin
               phase_in = (word_byte == BYTE_ESC) ? PHASE_ESC : PHASE_GROUND;
            end
         end
         default: begin
            phase_in = PHASE_GROUND;
         end
      endcase
   end

   // Advance state only when the word moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_GROUND;
         acc_ff        <= '0;
         digit_seen_ff <= 1'b0;
         pend_one_ff   <= 1'b0;
         pend_paste_ff <= 1'b0;
         flags_ff      <= '0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         acc_ff        <= acc_in;
         digit_seen_ff <= digit_seen_in;
         pend_one_ff   <= pend_one_in;
         pend_paste_ff <= pend_paste_in;
         flags_ff      <= flags_in;
      end
   end

   assign status.phase      = phase_ff;
   assign status.cur_flags  = flags_ff;
   assign status.next_flags = flags_in;

endmodule

>>> rtl/dpms_out_stage.sv
// Result register of the private-mode sniffer: holds one flag word.
// Depends on dpms_pkg.
module dpms_out_stage
   import dpms_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  flags_type load_flags,
   output logic      can_load,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output flags_type rsp_flags
);

   logic      valid_ff;
   logic      valid_in;
   flags_type flags_ff;

   // Free when empty or when the held word is taken this cycle
   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         flags_ff <= load_flags;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_flags = flags_ff;

endmodule

>>> dv/dec_mode_flag_checker.sv
// Checker for the private-mode sniffer: predicts both mode flags per byte word
// and compares them with every result word. Depends on dpms_pkg only.
module dec_mode_flag_checker
   import dpms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_app_cursor_keys,
   input  logic       rsp_bracketed_paste,
   output int         mismatch_count,
   output int         flags_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // Predicted parser state
   phase_type   parse_state;
   logic [15:0] number_value;
   logic        have_digit;
   logic        list_has_cursor;
   logic        list_has_paste;
   flags_type   predicted_flags;

   // Flags expected on the result channel, oldest first
   flags_type   expected_flags[$];
   int          errors;

   // Record a finished parameter if it names a known mode
   task close_number();
      if (number_value == MODE_CURSOR)
         list_has_cursor = 1'b1;
      else if (number_value == MODE_PASTE)
         list_has_paste = 1'b1;
   endtask

   task clear_param_list();
      number_value    = '0;
      have_digit      = 1'b0;
      list_has_cursor = 1'b0;
      list_has_paste  = 1'b0;
   endtask

   // Advance the predicted parser by one byte
   task parse_byte(input logic [7:0] b);
      int unsigned grown;
      case (parse_state)
         PHASE_GROUND: begin
            if (b == BYTE_ESC)
               parse_state = PHASE_ESC;
         end
         PHASE_ESC: begin
            if (b == BYTE_LBRACKET)
               parse_state = PHASE_CSI;
            else
               parse_state = PHASE_GROUND;
         end
         PHASE_CSI: begin
            if (b == BYTE_QUERY) begin
               parse_state = PHASE_PARAMS;
               clear_param_list();
            end else if (b == BYTE_ESC) begin
               parse_state = PHASE_ESC;
            end else begin
               parse_state = PHASE_GROUND;
            end
         end
         default: begin
            if (b >= BYTE_ZERO && b <= BYTE_NINE) begin
               // saturate instead of wrapping
               grown = number_value * 10 + (b - BYTE_ZERO);
               number_value = (grown > ACC_MAX) ? ACC_MAX : grown[15:0];
               have_digit = 1'b1;
            end else if (b == BYTE_SEMI) begin
               close_number();
               number_value = '0;
               have_digit   = 1'b0;
            end else if (b == BYTE_SET || b == BYTE_CLEAR) begin
               if (have_digit)
                  close_number();
               if (list_has_cursor)
                  predicted_flags.app_cursor_keys = (b == BYTE_SET);
               if (list_has_paste)
                  predicted_flags.bracketed_paste = (b == BYTE_SET);
               parse_state = PHASE_GROUND;
            end else if (b == BYTE_ESC) begin
               parse_state = PHASE_ESC;
            end else begin
               parse_state = PHASE_GROUND;
            end
         end
      endcase
   endtask

   // Compare result words, then predict for the accepted byte word
   always @(posedge clock) begin
      flags_type want;
      if (reset) begin
         parse_state     = PHASE_GROUND;
         clear_param_list();
         predicted_flags = '0;
         expected_flags.delete();
         errors          = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_flags.size() == 0) begin
               $display("%0t: result word with none expected (cursor %0b paste %0b)",
                        $time, rsp_app_cursor_keys, rsp_bracketed_paste);
               errors++;
            end else begin
               want = expected_flags[0];
               expected_flags.delete(0);
               if (rsp_app_cursor_keys !== want.app_cursor_keys) begin
                  $display("%0t: app_cursor_keys expected %0b got %0b",
                           $time, want.app_cursor_keys, rsp_app_cursor_keys);
                  errors++;
               end
               if (rsp_bracketed_paste !== want.bracketed_paste) begin
                  $display("%0t: bracketed_paste expected %0b got %0b",
                           $time, want.bracketed_paste, rsp_bracketed_paste);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            parse_byte(req_data_byte);
            expected_flags.insert(expected_flags.size(), predicted_flags);
         end
      end
      mismatch_count    <= errors;
      flags_outstanding <= expected_flags.size();
   end

endmodule

>>> dv/tb.sv
// Top of the private-mode sniffer testbench: clock, reset, byte stimulus and
// result back-pressure. Depends on dpms_pkg, the core and dec_mode_flag_checker.
module tb
   import dpms_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = '0;
   logic       rsp_valid;
   logic       rsp_ready     = 1'b0;
   logic       rsp_app_cursor_keys;
   logic       rsp_bracketed_paste;

   int         mismatch_count;
   int         flags_outstanding;
   logic       quiet         = 1'b0;
   int         stall_left    = 0;
   int         stall_draw;
   int         bytes_sent    = 0;
   logic [7:0] burst_bytes[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   dec_private_mode_sniffer_core u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_app_cursor_keys (rsp_app_cursor_keys),
      .rsp_bracketed_paste (rsp_bracketed_paste)
   );

   dec_mode_flag_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_app_cursor_keys (rsp_app_cursor_keys),
      .rsp_bracketed_paste (rsp_bracketed_paste),
      .mismatch_count      (mismatch_count),
      .flags_outstanding   (flags_outstanding)
   );

   // Stall the result channel at random after each word taken, unless quiet
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_ready) begin
         if (rsp_valid) begin
            stall_draw = quiet ? 0 : $urandom_range(0, 3);
            if (stall_draw != 0) begin
               rsp_ready  <= 1'b0;
               stall_left <= stall_draw - 1;
            end
         end
      end else if (stall_left == 0) begin
         rsp_ready <= 1'b1;
      end else begin
         stall_left <= stall_left - 1;
      end
   end

   // Offer one byte word after a random gap; return at the accepting edge
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   // Queue one byte at the tail of the burst
   task automatic add_byte(input logic [7:0] b);
      burst_bytes.insert(burst_bytes.size(), b);
   endtask

   // Append a decimal parameter, optionally with leading zeros
   task automatic append_number(input int unsigned v, input int unsigned zeros);
      logic [7:0] digits[$];
      repeat (zeros) add_byte(BYTE_ZERO);
      do begin
         digits.push_front(BYTE_ZERO + 8'(v % 10));
         v = v / 10;
      end while (v != 0);
      foreach (digits[i]) add_byte(digits[i]);
   endtask

   // Build one private-mode sequence with random parameters
   task automatic build_mode_sequence();
      int          n_params;
      int unsigned zeros;
      add_byte(BYTE_ESC);
      add_byte(BYTE_LBRACKET);
      add_byte(BYTE_QUERY);
      n_params = $urandom_range(0, 4);
      for (int p = 0; p < n_params; p++) begin
         if (p != 0)
            add_byte(BYTE_SEMI);
         zeros = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
         case ($urandom_range(0, 9))
            0, 1, 2: append_number(32'(MODE_CURSOR), zeros);
            3, 4, 5: append_number(32'(MODE_PASTE), zeros);
            6:       ;  // leave the parameter empty
            7:       append_number($urandom_range(0, 99999), zeros);
            8:       append_number($urandom_range(100000, 32'hffff_ffff), zeros);
            default: begin
               case ($urandom_range(0, 5))
                  0:       append_number(2, zeros);
                  1:       append_number(200, zeros);
                  2:       append_number(20040, zeros);
                  3:       append_number(11, zeros);
                  4:       append_number(65535, zeros);
                  default: append_number(65536, zeros);
               endcase
            end
         endcase
      end
      add_byte($urandom_range(0, 1) ? BYTE_SET : BYTE_CLEAR);
   endtask

   // Send the built burst, sometimes with a stray byte or ESC spliced in
   task automatic send_burst();
      int splice_at;
      splice_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, burst_bytes.size() - 1)
                                              : -1;
      foreach (burst_bytes[i]) begin
         if (i == splice_at)
            send_byte($urandom_range(0, 1) ? BYTE_ESC : 8'($urandom_range(0, 255)));
         send_byte(burst_bytes[i]);
      end
      burst_bytes.delete();
   endtask

   initial begin
      logic [7:0] directed[$];
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Set both modes in one list, then ESC ESC, then an ESC restart inside
      // the list followed by an empty parameter and a bare final, then clear
      directed = '{BYTE_ESC, BYTE_LBRACKET, BYTE_QUERY, BYTE_ZERO + 8'd1, BYTE_SEMI,
                   BYTE_ZERO + 8'd2, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO + 8'd4, BYTE_SET,
                   BYTE_ESC, BYTE_ESC, BYTE_LBRACKET,
                   BYTE_ESC, BYTE_LBRACKET, BYTE_QUERY, BYTE_ZERO + 8'd1,
                   BYTE_ESC, BYTE_LBRACKET, BYTE_QUERY, BYTE_SEMI, BYTE_CLEAR,
                   BYTE_ESC, BYTE_LBRACKET, BYTE_QUERY, BYTE_ZERO + 8'd1, BYTE_CLEAR};
      foreach (directed[i]) send_byte(directed[i]);

      // Mostly well-formed sequences, the rest raw noise
      while (bytes_sent < 1100) begin
         if ($urandom_range(0, 7) == 0)
            quiet <= ~quiet;
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 2) == 0) begin
               add_byte(BYTE_ESC);
               add_byte(BYTE_LBRACKET);
               add_byte(8'($urandom_range(0, 255)));
            end
         end else begin
            build_mode_sequence();
         end
         send_burst();
      end
      req_valid <= 1'b0;

      // Drain the results, then allow for any stray word
      @(posedge clock);
      while (flags_outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Give up if the run hangs
   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/dpms_pkg.sv
rtl/dpms_in_stage.sv
rtl/dpms_parser.sv
rtl/dpms_out_stage.sv
rtl/dec_private_mode_sniffer_core.sv
dv/dec_mode_flag_checker.sv
dv/tb.sv
